/* sv/lmfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfd_pkg: shared types and constants for the length/magic frame deframer
// Result kinds, the result word, configuration and reset values.
// ----------------------------------------------------------------------------
package lmfd_pkg;

   localparam int unsigned DataWidth  = 8;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned HdrBytes   = 8;
   localparam int unsigned HdrCntBits = $clog2(HdrBytes);

   localparam logic [WordWidth-1:0] MaxLenReset = 32'd134217728;
   localparam logic [WordWidth-1:0] MagicReset  = 32'h4E45_4958;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_MAX_LEN = 1'b0,
      CSR_MAGIC   = 1'b1
   } csr_index_type;

   // Input action codes
   typedef enum logic [0:0] {
      ACT_BYTE = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_PROTO_ERR = 2'd2,
      KIND_STREAM_END = 2'd3
   } kind_type;

   typedef struct packed {
      logic [WordWidth-1:0] max_len;
      logic [WordWidth-1:0] magic;
   } cfg_type;

   typedef struct packed {
      kind_type             kind;
      logic [DataWidth-1:0] payload_byte;
      logic                 last_of_message;
   } rsp_word_type;

endpackage

/* sv/lmfd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfd_if: valid/ready channels of the deframer
// Request channel carries stream words, response channel carries results.
// ----------------------------------------------------------------------------
interface lmfd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface lmfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic       last_of_message;

   modport source (output valid, output kind, output payload_byte,
                   output last_of_message, input ready);
   modport sink   (input valid, input kind, input payload_byte,
                   input last_of_message, output ready);
endinterface

/* sv/lmfd_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfd_csr: configuration registers
// Holds the maximum payload length and the expected magic word.
// ----------------------------------------------------------------------------
module lmfd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [lmfd_pkg::WordWidth-1:0] csr_wdata,
   output lmfd_pkg::cfg_type             cfg
);
   import lmfd_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_len <= MaxLenReset;
         cfg_ff.magic   <= MagicReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_LEN: cfg_ff.max_len <= csr_wdata;
            CSR_MAGIC:   cfg_ff.magic   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/lmfd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfd_parser: header collection, check and payload count
// Updates frame state per accepted word and forms at most one result.
// ----------------------------------------------------------------------------
module lmfd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          action,
   input  logic [lmfd_pkg::DataWidth-1:0] rx_byte,
   input  lmfd_pkg::cfg_type             cfg,
   output logic                          push,
   output lmfd_pkg::rsp_word_type        result
);
   import lmfd_pkg::*;

   localparam int unsigned HdrBits = HdrBytes * DataWidth;

   logic                  in_payload_ff, in_payload_in;
   logic [HdrCntBits-1:0] hdr_count_ff, hdr_count_in;
   logic [HdrBits-1:0]    hdr_shift_ff, hdr_shift_in;
   logic [WordWidth-1:0]  remaining_ff, remaining_in;
   logic                  latched_ff, latched_in;

   logic [HdrBits-1:0]    hdr_next;
   logic [WordWidth-1:0]  hdr_len;
   logic [WordWidth-1:0]  hdr_magic;
   logic                  pay_last;

   assign hdr_next  = {rx_byte, hdr_shift_ff[HdrBits-1:DataWidth]};
   assign hdr_len   = hdr_next[WordWidth-1:0];
   assign hdr_magic = hdr_next[HdrBits-1:WordWidth];
   assign pay_last  = (remaining_ff <= WordWidth'(1));

   always_comb begin
      in_payload_in = in_payload_ff;
      hdr_count_in  = hdr_count_ff;
      hdr_shift_in  = hdr_shift_ff;
      remaining_in  = remaining_ff;
      latched_in    = latched_ff;
      push          = 1'b0;
      result.kind            = KIND_PAYLOAD;
      result.payload_byte    = '0;
      result.last_of_message = 1'b0;

      if (accept && !latched_ff) begin
         if (action_type'(action) == ACT_END) begin
            latched_in  = 1'b1;
            push        = 1'b1;
            result.kind = KIND_STREAM_END;
         end else if (in_payload_ff) begin
            push                   = 1'b1;
            result.payload_byte    = rx_byte;
            result.last_of_message = pay_last;
            if (pay_last) begin
               in_payload_in = 1'b0;
               remaining_in  = '0;
            end else begin
               remaining_in = remaining_ff - WordWidth'(1);
            end
         end else if (hdr_count_ff != HdrCntBits'(HdrBytes - 1)) begin
            hdr_shift_in = hdr_next;
            hdr_count_in = hdr_count_ff + HdrCntBits'(1);
         end else begin
            // eighth header byte: check length and magic
            hdr_count_in = '0;
            hdr_shift_in = '0;
            if ((hdr_len > cfg.max_len) || (hdr_magic != cfg.magic)) begin
               latched_in  = 1'b1;
               push        = 1'b1;
               result.kind = KIND_PROTO_ERR;
            end else if (hdr_len == '0) begin
               push                   = 1'b1;
               result.kind            = KIND_EMPTY;
               result.last_of_message = 1'b1;
            end else begin
               in_payload_in = 1'b1;
               remaining_in  = hdr_len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         hdr_count_ff  <= '0;
         hdr_shift_ff  <= '0;
         remaining_ff  <= '0;
         latched_ff    <= 1'b0;
      end else begin
         in_payload_ff <= in_payload_in;
         hdr_count_ff  <= hdr_count_in;
         hdr_shift_ff  <= hdr_shift_in;
         remaining_ff  <= remaining_in;
         latched_ff    <= latched_in;
      end
   end

endmodule

/* sv/lmfd_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfd_skid: result register with skid stage
// Two-entry output buffer; ready toward the parser is a register.
// ----------------------------------------------------------------------------
module lmfd_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lmfd_pkg::rsp_word_type push_word,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lmfd_pkg::rsp_word_type out_word
);
   import lmfd_pkg::*;

   rsp_word_type out_ff, skid_ff;
   logic         out_valid_ff, skid_valid_ff;
   logic         pop;

   assign pop = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_ff <= push_word;
         end else begin
            skid_ff <= push_word;
         end
      end
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule

/* sv/length_magic_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_magic_frame_deframer: length-prefixed frame deframer, magic check
// Splits a byte stream into frames of an 8-byte header (length, magic,
// both little-endian) and payload, and passes payload bytes straight on.
// ----------------------------------------------------------------------------
//
//  channel   direction  word                                 handshake
//  --------  ---------  -----------------------------------  -----------
//  req_if    in         action, rx_byte                      valid/ready
//  rsp_if    out        kind, payload_byte, last_of_message  valid/ready
//  csr_*     in         index, 32-bit data                   write enable
//
//  One word per cycle while rsp_if keeps up; a result appears on rsp_if the
//  cycle after its word is taken unless rsp_if stalls. Header words give
//  no result, but for the eighth on an empty frame or an error. Reset is
//  synchronous and active high; config returns to its reset values. A
//  stalled rsp_if fills the result register and then the skid stage;
//  req_if.ready drops only while the skid stage holds a word. After a
//  protocol error or stream end, drop all later words until reset.
module length_magic_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   lmfd_req_if.sink                       req_if,
   lmfd_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [lmfd_pkg::WordWidth-1:0] csr_wdata
);
   import lmfd_pkg::*;

   cfg_type      cfg;
   rsp_word_type parse_word;
   rsp_word_type out_word;
   logic         parse_push;
   logic         space;
   logic         accept;

   // take a word whenever the skid stage is empty
   assign req_if.ready = space;
   assign accept       = req_if.valid && space;

   lmfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // header collection, check and payload count
   lmfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_if.action),
      .rx_byte (req_if.rx_byte),
      .cfg     (cfg),
      .push    (parse_push),
      .result  (parse_word)
   );

   // hold results until the consumer takes them
   lmfd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_push),
      .push_word (parse_word),
      .space     (space),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_word  (out_word)
   );

   assign rsp_if.kind            = out_word.kind;
   assign rsp_if.payload_byte    = out_word.payload_byte;
   assign rsp_if.last_of_message = out_word.last_of_message;

endmodule

/* sim/tb_length_magic_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_magic_frame_deframer: self-checking bench for the frame deframer
// Streams well-formed frames with random payload under three idle mixes and
// several register settings. A scoreboard class predicts every result word.
// The run closes with one latching event (bad length, bad magic or an end
// word) picked at random, then feeds words that must be dropped.
// ----------------------------------------------------------------------------
module tb_length_magic_frame_deframer;
   import lmfd_pkg::*;

   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned HoldCycles = 300;

   // Scoreboard: a private copy of the deframer state and its registers,
   // plus the queue of result words still to come out of the block.
   class frame_result_board;
      cfg_type              regs;
      bit                   in_payload;
      logic [2:0]           hdr_count;
      logic [63:0]          hdr_shift;
      logic [31:0]          remaining;
      bit                   latched;
      rsp_word_type         expected_results[$];
      int unsigned          mismatches;
      int unsigned          kind_seen[4];

      function new();
         regs.max_len = MaxLenReset;
         regs.magic   = MagicReset;
         in_payload   = 1'b0;
         hdr_count    = '0;
         hdr_shift    = '0;
         remaining    = '0;
         latched      = 1'b0;
         mismatches   = 0;
      endfunction

      function void load_register(csr_index_type idx, logic [31:0] value);
         if (idx == CSR_MAX_LEN) regs.max_len = value;
         else regs.magic = value;
      endfunction

      function void push_result(kind_type kind, logic [7:0] data, logic last);
         rsp_word_type r;
         r.kind            = kind;
         r.payload_byte    = data;
         r.last_of_message = last;
         expected_results.insert(expected_results.size(), r);
      endfunction

      // Advance the deframer copy by one accepted word.
      function void take_word(action_type act, logic [7:0] data);
         logic [31:0] len;
         logic [31:0] magic;
         logic        last;
         if (latched) return;
         if (act == ACT_END) begin
            latched = 1'b1;
            push_result(KIND_STREAM_END, 8'h00, 1'b0);
            return;
         end
         if (in_payload) begin
            last = (remaining <= 32'd1);
            if (remaining != 0) remaining--;
            if (last) begin
               in_payload = 1'b0;
               remaining  = '0;
            end
            push_result(KIND_PAYLOAD, data, last);
            return;
         end
         // Header bytes enter from the top: length ends low, magic high.
         hdr_shift = {data, hdr_shift[63:8]};
         if (hdr_count != 3'd7) begin
            hdr_count++;
            return;
         end
         hdr_count = '0;
         len       = hdr_shift[31:0];
         magic     = hdr_shift[63:32];
         hdr_shift = '0;
         if (len > regs.max_len || magic != regs.magic) begin
            latched = 1'b1;
            push_result(KIND_PROTO_ERR, 8'h00, 1'b0);
         end else if (len == 0) begin
            push_result(KIND_EMPTY, 8'h00, 1'b1);
         end else begin
            in_payload = 1'b1;
            remaining  = len;
         end
      endfunction

      function void note_mismatch(string what, rsp_word_type want, rsp_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] mismatch %0d, %s: expected kind=%0d byte=%02h last=%0b,",
                     $time, mismatches, what, want.kind, want.payload_byte,
                     want.last_of_message,
                     " got kind=%0d byte=%02h last=%0b",
                     got.kind, got.payload_byte, got.last_of_message);
      endfunction

      function void match_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_results.size() == 0) begin
            note_mismatch("nothing pending", '0, got);
            return;
         end
         want = expected_results[0];
         expected_results.delete(0);
         kind_seen[int'(want.kind)]++;
         if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
             got.last_of_message !== want.last_of_message)
            note_mismatch("field differs", want, got);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [0:0]        csr_index;
   logic [31:0]       csr_wdata;

   lmfd_req_if req_ch ();
   lmfd_rsp_if rsp_ch ();

   frame_result_board board = new();

   int unsigned  cycle_count   = 0;
   int unsigned  words_sent    = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  hold_left     = 0;
   bit           hold_request  = 1'b0;
   logic [31:0]  cur_max;
   logic [31:0]  cur_magic;
   string        closing_case;
   rsp_word_type seen_word;

   length_magic_frame_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count++;

   // Watchdog: end the run if the block stops making progress.
   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("[%0t] watchdog expired with %0d results pending", $time,
               board.expected_results.size());
      $display("tb_length_magic_frame_deframer: errors");
      $finish;
   end

   // Monitor: check the result word first, then note the accepted input
   // word, so a word's own result can never race its prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_word.kind            = kind_type'(rsp_ch.kind);
            seen_word.payload_byte    = rsp_ch.payload_byte;
            seen_word.last_of_message = rsp_ch.last_of_message;
            board.match_result(seen_word);
         end
         if (req_ch.valid && req_ch.ready)
            board.take_word(action_type'(req_ch.action), req_ch.rx_byte);
      end
   end

   // Receiver: random back-pressure, or a long hold when one is requested.
   // The hold is counted here so the sender can keep pushing meanwhile.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HoldCycles;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one word; idle first at the sender's rate, then hold it until taken.
   // Enter and leave at a falling edge.
   task automatic send_word(action_type act, logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Send a 32-bit header field, low byte first.
   task automatic send_field(logic [31:0] value);
      for (int i = 0; i < 4; i++) send_word(ACT_BYTE, value[8*i +: 8]);
   endtask

   task automatic send_payload(logic [31:0] count);
      for (int unsigned i = 0; i < count; i++) send_word(ACT_BYTE, 8'($urandom));
   endtask

   task automatic send_frame(logic [31:0] len, logic [31:0] magic);
      send_field(len);
      send_field(magic);
      send_payload(len);
   endtask

   // Drop valid and wait until every predicted result has come out, then a
   // few more cycles for header words still moving through the block.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Write both registers on back-to-back cycles; only call when drained.
   task automatic write_config(logic [31:0] max_len, logic [31:0] magic);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= max_len;
      @(posedge clock);
      board.load_register(CSR_MAX_LEN, max_len);
      @(negedge clock);
      csr_index <= CSR_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      board.load_register(CSR_MAGIC, magic);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_max   = max_len;
      cur_magic = magic;
   endtask

   task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      @(negedge clock);
   endtask

   task automatic hold_receiver();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
   endtask

   // Mostly short frames; hit zero often and the limit itself when it is 64 or
   // less, and send a long frame now and then when the limit allows it.
   function automatic logic [31:0] pick_length(logic [31:0] limit);
      logic [31:0] cap;
      int unsigned r;
      cap = (limit < 32'd24) ? limit : 32'd24;
      r   = $urandom_range(99);
      if (r < 8) return 32'd0;
      if (r < 14 && limit <= 32'd64) return limit;
      if (r < 17 && limit >= 32'd260) return $urandom_range(260, 120);
      return $urandom_range(cap, 0);
   endfunction

   task automatic run_frames(int unsigned count);
      int unsigned start;
      start = words_sent;
      while (words_sent - start < count) send_frame(pick_length(cur_max), cur_magic);
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.action  = ACT_BYTE;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_MAX_LEN;
      csr_wdata      = '0;
      cur_max        = MaxLenReset;
      cur_magic      = MagicReset;
      send_idle_pct  = 18;
      recv_idle_pct  = 76;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty frame on the reset registers.
      send_frame(32'd0, MagicReset);
      // Change both registers between the length and the magic of one
      // header; the new values must apply at the check. Length equals max.
      send_field(32'd2);
      wait_drained();
      write_config(32'd2, 32'hFFFF_FFFF);
      send_field(32'hFFFF_FFFF);
      send_payload(32'd2);
      wait_drained();
      // Zero limit and zero magic: only empty frames pass.
      write_config(32'd0, 32'd0);
      send_frame(32'd0, 32'd0);
      wait_drained();

      // Random phase one: sender idles lightly, receiver heavily.
      write_config($urandom_range(48, 8), $urandom);
      run_frames(630);
      wait_drained();

      // Random phase two: swap the idle rates, open the length limit fully.
      set_idle(76, 18);
      write_config(32'hFFFF_FFFF, $urandom);
      run_frames(630);
      wait_drained();

      // Random phase three: no idling; back to the power-on register values.
      set_idle(0, 0);
      write_config(MaxLenReset, MagicReset);
      run_frames(300);
      // Hold the receiver off while a long frame streams in, so the result
      // path fills and the block stalls its input.
      hold_receiver();
      send_frame(32'd60, cur_magic);
      run_frames(150);
      // Pause the sender until the block has emptied, then carry on.
      wait_drained();
      run_frames(180);
      wait_drained();

      // Close with one latching event, then words that must all be dropped.
      case ($urandom_range(3))
         0: begin
            closing_case = "oversized length";
            send_field($urandom | 32'h8000_0000);
            send_field(cur_magic);
         end
         1: begin
            closing_case = "wrong magic";
            send_field(32'd5);
            send_field(cur_magic ^ (32'd1 << $urandom_range(31)));
         end
         2: begin
            closing_case = "end word inside a payload";
            send_field(32'd10);
            send_field(cur_magic);
            send_payload(32'd4);
            send_word(ACT_END, 8'($urandom));
         end
         default: begin
            closing_case = "end word inside a header";
            send_word(ACT_BYTE, 8'($urandom));
            send_word(ACT_BYTE, 8'($urandom));
            send_word(ACT_BYTE, 8'($urandom));
            send_word(ACT_END, 8'($urandom));
         end
      endcase
      send_frame(32'd0, cur_magic);
      send_word(ACT_END, 8'($urandom));
      send_payload(32'd6);

      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d words: %0d payload bytes, %0d empty frames, %0d errors, %0d ends",
               words_sent, board.kind_seen[int'(KIND_PAYLOAD)],
               board.kind_seen[int'(KIND_EMPTY)], board.kind_seen[int'(KIND_PROTO_ERR)],
               board.kind_seen[int'(KIND_STREAM_END)]);
      $display("idle mixes 18/76, 76/18, 0/0, one %0d-cycle receiver hold; closed by %s",
               HoldCycles, closing_case);
      if (board.mismatches == 0) begin
         $display("tb_length_magic_frame_deframer: clean");
      end else begin
         $display("tb_length_magic_frame_deframer: errors");
      end
      $finish;
   end

endmodule
